// ===== hdl/sse_pkg.sv =====
// Package with the shared types and codes of the sorted set engine.
`timescale 1ns / 1ps
package sse_pkg;

  typedef enum logic [2:0] {
    CMD_INS_A = 3'd0,
    CMD_INS_B = 3'd1,
    CMD_INTER = 3'd2,
    CMD_UNION = 3'd3,
    CMD_DIFF  = 3'd4,
    CMD_CLEAR = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INSERTED = 3'd0,
    ST_DUP      = 3'd1,
    ST_FULL     = 3'd2,
    ST_ELEM     = 3'd3,
    ST_EMPTY    = 3'd4,
    ST_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INSERT,
    S_MERGE,
    S_EMPTY,
    S_SINGLE
  } state_t;

  typedef struct packed {
    logic [2:0]         command;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] result_value;
    logic               last;
  } out_item_t;

  // Shift control sent along one row of cells.
  typedef struct packed {
    logic        ins;
    logic        shift;
    logic [31:0] value;
  } cell_ctl_t;

endpackage

// ===== hdl/sse_cell.sv =====
// One storage cell of a set row: holds one value and a valid bit.
`timescale 1ns / 1ps
module sse_cell
  import sse_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  logic        head,
  input  cell_ctl_t   ctl,
  input  logic        prev_valid,
  input  logic [31:0] prev_value,
  input  logic        next_valid,
  input  logic [31:0] next_value,
  output logic        valid,
  output logic [31:0] value
);

  logic        gt;
  logic        prev_gt;
  logic [31:0] value_next;
  logic        valid_next;

  assign gt = valid && ($signed(value) > $signed(ctl.value));
  assign prev_gt = prev_valid && ($signed(prev_value) > $signed(ctl.value));

  always_comb begin
    value_next = value;
    valid_next = valid;
    if (ctl.ins) begin
      if (prev_gt) begin
        value_next = prev_value;
        valid_next = prev_valid;
      end else if ((gt || !valid) && (prev_valid ? !prev_gt : head)) begin
        value_next = ctl.value;
        valid_next = 1'b1;
      end
    end else if (ctl.shift) begin
      value_next = next_value;
      valid_next = next_valid;
    end
  end

  always_ff @(posedge clk) begin
    value <= value_next;
    if (rst || clear) begin
      valid <= 1'b0;
    end else begin
      valid <= valid_next;
    end
  end

endmodule

// ===== hdl/sse_row.sv =====
// A row of cells holding one sorted set, inserting in place and rotating for reads.
`timescale 1ns / 1ps
module sse_row
  import sse_pkg::*;
#(
  parameter int Depth = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        clear,
  input  cell_ctl_t   ctl,
  output logic        head_valid,
  output logic [31:0] head_value,
  output logic        full,
  output logic        has_dup
);

  logic [Depth-1:0] valid;
  logic [31:0]      value [Depth];
  logic [Depth-1:0] eq;

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic        pv;
    logic [31:0] pval;
    logic        nv;
    logic [31:0] nval;
    if (i == 0) begin : g_first
      assign pv   = 1'b0;
      assign pval = '0;
    end else begin : g_mid
      assign pv   = valid[i-1];
      assign pval = value[i-1];
    end
    // Rotation moves the head to the tail so a full pass restores the row.
    if (i == Depth - 1) begin : g_last
      assign nv   = valid[0];
      assign nval = value[0];
    end else begin : g_inner
      assign nv   = valid[i+1];
      assign nval = value[i+1];
    end
    sse_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .clear      (clear),
      .head       (i == 0),
      .ctl        (ctl),
      .prev_valid (pv),
      .prev_value (pval),
      .next_valid (nv),
      .next_value (nval),
      .valid      (valid[i]),
      .value      (value[i])
    );
    assign eq[i] = valid[i] && (value[i] == ctl.value);
  end

  assign head_valid = valid[0];
  assign head_value = value[0];
  assign full       = valid[Depth-1];
  assign has_dup    = |eq;

endmodule

// ===== hdl/sorted_set_engine_with_set_ops_unit.sv =====
// Top level of the sorted set engine with intersection, union and difference.
// Insert and clear each return one status result; set operations return their elements
// in order with the final one marked last, or an empty status when there are none,
// at most one result per cycle; a result waiting on the consumer stalls the merge.
// One request at a time: ready returns once the final result is loaded (taken, for set ops).
// Synchronous active high reset empties both sets and the output register.
`timescale 1ns / 1ps
module sorted_set_engine_with_set_ops_unit
  import sse_pkg::*;
#(
  parameter int SET_DEPTH = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  localparam int CW = $clog2(2 * SET_DEPTH + 1);

  state_t      state, state_next;
  logic [2:0]  cmd;
  logic [31:0] val;
  logic [CW-1:0] ca, cb;
  logic        emitted;
  out_item_t   single;

  cell_ctl_t   ctl_a, ctl_b;
  logic        clear;
  logic        a_v, b_v, a_full, b_full, a_dup, b_dup;
  logic [31:0] a_h, b_h;
  logic        slot_free;
  logic        take_a, take_b, emit;
  logic [31:0] ev;
  logic        out_load;

  sse_row #(.Depth(SET_DEPTH)) u_row_a (
    .clk(clk), .rst(rst), .clear(clear), .ctl(ctl_a),
    .head_valid(a_v), .head_value(a_h), .full(a_full), .has_dup(a_dup)
  );
  sse_row #(.Depth(SET_DEPTH)) u_row_b (
    .clk(clk), .rst(rst), .clear(clear), .ctl(ctl_b),
    .head_valid(b_v), .head_value(b_h), .full(b_full), .has_dup(b_dup)
  );

  assign slot_free = !out_valid || out_ready;
  assign in_ready  = (state == S_IDLE);

  // Merge step: a head is live while its rotate count is below depth and it is valid.
  logic la, lb;
  assign la = (ca < CW'(SET_DEPTH)) && a_v;
  assign lb = (cb < CW'(SET_DEPTH)) && b_v;

  always_comb begin
    take_a = 1'b0;
    take_b = 1'b0;
    emit   = 1'b0;
    ev     = a_h;
    if (la && lb && a_h == b_h) begin
      take_a = 1'b1;
      take_b = 1'b1;
      emit   = (cmd == CMD_INTER) || (cmd == CMD_UNION);
    end else if (la && (!lb || $signed(a_h) < $signed(b_h))) begin
      take_a = 1'b1;
      emit   = (cmd == CMD_UNION) || (cmd == CMD_DIFF);
    end else if (lb) begin
      take_b = 1'b1;
      ev     = b_h;
      emit   = (cmd == CMD_UNION);
    end
  end

  // Lookahead for last: peek whether a later step emits is costly, so results
  // are held one step in a pending register and flushed at the end.
  logic        pend;
  logic [31:0] pend_v;
  logic        step;

  assign step = (state == S_MERGE) && slot_free && (la || lb);

  assign out_load = slot_free && (((state == S_MERGE) && step && emit && pend)
                    || (state == S_EMPTY) || ((state == S_SINGLE) && !emitted));

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_data.command)
            CMD_INS_A, CMD_INS_B:          state_next = S_INSERT;
            CMD_INTER, CMD_UNION, CMD_DIFF: state_next = S_MERGE;
            CMD_CLEAR:                     state_next = S_SINGLE;
            default:                       state_next = S_IDLE;
          endcase
        end
      end
      S_INSERT: state_next = S_SINGLE;
      S_MERGE: begin
        if (ca == CW'(SET_DEPTH) && cb == CW'(SET_DEPTH)) state_next = S_EMPTY;
      end
      S_EMPTY:  if (slot_free) state_next = S_SINGLE;
      S_SINGLE: if (slot_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    ctl_a = '{ins: 1'b0, shift: 1'b0, value: val};
    ctl_b = '{ins: 1'b0, shift: 1'b0, value: val};
    clear = 1'b0;
    if (state == S_INSERT) begin
      ctl_a.ins = (cmd == CMD_INS_A) && !a_dup && !a_full;
      ctl_b.ins = (cmd == CMD_INS_B) && !b_dup && !b_full;
    end
    if (state == S_IDLE && in_valid && in_data.command == CMD_CLEAR) clear = 1'b1;
    // Rows that finished rotate the rest of the way so they end restored.
    if (state == S_MERGE && slot_free) begin
      ctl_a.shift = take_a || (!la && ca < CW'(SET_DEPTH));
      ctl_b.shift = take_b || (!lb && cb < CW'(SET_DEPTH));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      pend      <= 1'b0;
      emitted   <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (state == S_IDLE && in_valid) begin
        cmd     <= in_data.command;
        val     <= in_data.value;
        ca      <= '0;
        cb      <= '0;
        pend    <= 1'b0;
        emitted <= 1'b0;
        single  <= '{status: ST_CLEARED, result_value: '0, last: 1'b1};
      end
      if (state == S_INSERT) begin
        if (cmd == CMD_INS_A) begin
          single.status <= a_dup ? ST_DUP : (a_full ? ST_FULL : ST_INSERTED);
        end else begin
          single.status <= b_dup ? ST_DUP : (b_full ? ST_FULL : ST_INSERTED);
        end
      end
      if (state == S_MERGE && slot_free) begin
        if (ctl_a.shift) ca <= ca + CW'(1);
        if (ctl_b.shift) cb <= cb + CW'(1);
        if (step && emit) begin
          pend   <= 1'b1;
          pend_v <= ev;
          if (pend) begin
            out_data <= '{status: ST_ELEM, result_value: pend_v, last: 1'b0};
          end
        end
      end
      if (state == S_EMPTY && slot_free) begin
        emitted <= 1'b1;
        if (pend) begin
          out_data <= '{status: ST_ELEM, result_value: pend_v, last: 1'b1};
        end else begin
          out_data <= '{status: ST_EMPTY, result_value: '0, last: 1'b1};
        end
      end
      if (state == S_SINGLE && slot_free && !emitted) begin
        out_data <= single;
      end
    end
  end

endmodule

// ===== hdl/sse_checker.sv =====
// Port-level checker for the sorted set engine, bound to the top level.
`timescale 1ns / 1ps
module sse_checker
  import sse_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_ready,
  input in_item_t  in_data,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("Stalled result changed.");

  a_val_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_ELEM |-> out_data.result_value == 0)
    else $error("Non-element result carries a value.");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.status != ST_ELEM |-> out_data.last)
    else $error("Status result not marked last.");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.last |-> !in_ready)
    else $error("Request taken mid-stream.");

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_ready |=> in_valid && $stable(in_data))
    else $error("Waiting request changed.");

endmodule

bind sorted_set_engine_with_set_ops_unit sse_checker u_sse_checker (.*);
